[rtl/brb_pkg.sv]
package brb_pkg;

   // command codes
   localparam logic [2:0] CMD_WRITE     = 3'd0;
   localparam logic [2:0] CMD_READ      = 3'd1;
   localparam logic [2:0] CMD_PEEK      = 3'd2;
   localparam logic [2:0] CMD_ADVANCE   = 3'd3;
   localparam logic [2:0] CMD_UNADVANCE = 3'd4;

   // status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_SHORT  = 2'd1;
   localparam logic [1:0] ST_BADLEN = 2'd2;

   localparam int CMD_W  = 3;
   localparam int LEN_W  = 7;
   localparam int WB_W   = 64;
   localparam int BYTE_W = 8;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 32;

   typedef struct packed {
      logic we;
      logic re;
   } mem_ctl_type;

endpackage

[rtl/brb_store.sv]
module brb_store #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic                      clock,
   input  brb_pkg::mem_ctl_type      mem_ctl,
   input  logic [AW-1:0]             addr,
   input  logic [brb_pkg::BYTE_W-1:0] wr_data,
   output logic [brb_pkg::BYTE_W-1:0] rd_data
);
   import brb_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   // single port; read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (mem_ctl.we) begin
         mem[addr] <= wr_data;
      end
      if (mem_ctl.re) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/brb_ctrl.sv]
module brb_ctrl #(
   parameter int CAPACITY     = 255,
   parameter int MAX_TRANSFER = 64,
   parameter int WRITE_LANES  = 8,
   parameter int AW           = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [brb_pkg::CMD_W-1:0]   req_command,
   input  logic [brb_pkg::LEN_W-1:0]   req_length,
   input  logic [brb_pkg::WB_W-1:0]    req_write_bytes,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic                        rsp_tlast,
   output logic [1:0]                  rsp_status,
   output logic [brb_pkg::BYTE_W-1:0]  rsp_data_byte,
   output logic [brb_pkg::BYTE_W-1:0]  rsp_fill_level,
   output logic [brb_pkg::BYTE_W-1:0]  rsp_free_space,
   output brb_pkg::mem_ctl_type        mem_ctl,
   output logic [AW-1:0]               mem_addr,
   output logic [brb_pkg::BYTE_W-1:0]  mem_wr_data,
   input  logic [brb_pkg::BYTE_W-1:0]  mem_rd_data
);
   import brb_pkg::*;

   localparam int LW = ((AW > LEN_W) ? AW : LEN_W) + 1;
   localparam logic [LW-1:0] SLOTS_L   = LW'(CAPACITY + 1);
   localparam logic [LW-1:0] CAP_L     = LW'(CAPACITY);
   localparam logic [LW-1:0] MAXT_L    = LW'(MAX_TRANSFER);
   localparam logic [LW-1:0] LANES_L   = LW'(WRITE_LANES);
   localparam logic [AW-1:0] PTR_LAST  = AW'(CAPACITY);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_WRITE = 2'd1;
   localparam logic [1:0] S_READ  = 2'd2;
   localparam logic [1:0] S_FIN   = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [AW-1:0]     tail_ff, tail_in;
   logic [AW-1:0]     rp_ff, rp_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic [LEN_W-1:0]  outcnt_ff, outcnt_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [WB_W-1:0]   wb_ff, wb_in;
   logic [1:0]        status_ff, status_in;
   logic [BYTE_W-1:0] fill_ff, fill_in;
   logic [BYTE_W-1:0] free_ff, free_in;
   logic              rdv_ff, rdv_in;
   logic              ov_ff, ov_in;
   logic [1:0]        o_status_ff, o_status_in;
   logic [BYTE_W-1:0] o_data_ff, o_data_in;
   logic              o_last_ff, o_last_in;
   logic [BYTE_W-1:0] o_fill_ff, o_fill_in;
   logic [BYTE_W-1:0] o_free_ff, o_free_in;

   always_comb begin
      logic [LW-1:0] headx, tailx, lenx, fill, space, post_fill, post_free, sum;
      logic          out_free, move1, issue, last_byte;

      state_in    = state_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      rp_in       = rp_ff;
      cnt_in      = cnt_ff;
      outcnt_in   = outcnt_ff;
      len_in      = len_ff;
      wb_in       = wb_ff;
      status_in   = status_ff;
      fill_in     = fill_ff;
      free_in     = free_ff;
      rdv_in      = rdv_ff;
      o_status_in = o_status_ff;
      o_data_in   = o_data_ff;
      o_last_in   = o_last_ff;
      o_fill_in   = o_fill_ff;
      o_free_in   = o_free_ff;
      mem_ctl     = '0;
      mem_addr    = rp_ff;
      mem_wr_data = wb_ff[BYTE_W-1:0];

      headx     = LW'(head_ff);
      tailx     = LW'(tail_ff);
      lenx      = LW'(req_length);
      fill      = (tailx >= headx) ? (tailx - headx) : (tailx + SLOTS_L - headx);
      space     = CAP_L - fill;
      post_fill = fill;
      post_free = space;
      sum       = '0;

      out_free  = !ov_ff || rsp_tready;
      move1     = 1'b0;
      issue     = 1'b0;
      last_byte = 1'b0;
      ov_in     = ov_ff && !rsp_tready;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               len_in    = req_length;
               cnt_in    = req_length;
               outcnt_in = '0;
               wb_in     = req_write_bytes;
               rp_in     = head_ff;
               status_in = ST_OK;
               state_in  = S_FIN;
               if (req_command == CMD_WRITE) begin
                  if (lenx > LANES_L) begin
                     status_in = ST_BADLEN;
                  end else if (lenx > space) begin
                     status_in = ST_SHORT;
                  end else begin
                     post_fill = fill + lenx;
                     if (req_length != '0) begin
                        state_in = S_WRITE;
                     end
                  end
               end else if (req_command > CMD_UNADVANCE || lenx > MAXT_L) begin
                  status_in = ST_BADLEN;
               end else if (req_command == CMD_READ || req_command == CMD_PEEK) begin
                  if (lenx > fill) begin
                     status_in = ST_SHORT;
                  end else if (req_length != '0) begin
                     state_in = S_READ;
                     if (req_command == CMD_READ) begin
                        post_fill = fill - lenx;
                        sum       = headx + lenx;
                        if (sum >= SLOTS_L) begin
                           sum = sum - SLOTS_L;
                        end
                        head_in = sum[AW-1:0];
                     end
                  end
               end else if (req_length == '0) begin
                  status_in = ST_BADLEN;
               end else if (req_command == CMD_ADVANCE) begin
                  if (lenx > fill) begin
                     status_in = ST_SHORT;
                  end else begin
                     post_fill = fill - lenx;
                     sum       = headx + lenx;
                     if (sum >= SLOTS_L) begin
                        sum = sum - SLOTS_L;
                     end
                     head_in = sum[AW-1:0];
                  end
               end else begin
                  if (lenx > space) begin
                     status_in = ST_SHORT;
                  end else begin
                     post_fill = fill + lenx;
                     sum = (headx >= lenx) ? (headx - lenx) : (headx + SLOTS_L - lenx);
                     head_in = sum[AW-1:0];
                  end
               end
               post_free = CAP_L - post_fill;
               fill_in   = post_fill[BYTE_W-1:0];
               free_in   = post_free[BYTE_W-1:0];
            end
         end
         S_WRITE: begin
            mem_ctl.we  = 1'b1;
            mem_addr    = tail_ff;
            tail_in     = (tail_ff == PTR_LAST) ? '0 : tail_ff + AW'(1);
            wb_in       = wb_ff >> BYTE_W;
            cnt_in      = cnt_ff - LEN_W'(1);
            if (cnt_ff == LEN_W'(1)) begin
               state_in = S_FIN;
            end
         end
         S_READ: begin
            // two-stage flow: memory read register, then output register
            move1 = rdv_ff && out_free;
            issue = (cnt_ff != '0) && (!rdv_ff || move1);
            if (issue) begin
               mem_ctl.re = 1'b1;
               rp_in      = (rp_ff == PTR_LAST) ? '0 : rp_ff + AW'(1);
               cnt_in     = cnt_ff - LEN_W'(1);
            end
            rdv_in = issue || (rdv_ff && !move1);
            if (move1) begin
               last_byte   = (outcnt_ff + LEN_W'(1)) == len_ff;
               outcnt_in   = outcnt_ff + LEN_W'(1);
               ov_in       = 1'b1;
               o_status_in = ST_OK;
               o_data_in   = mem_rd_data;
               o_last_in   = last_byte;
               o_fill_in   = fill_ff;
               o_free_in   = free_ff;
               if (last_byte) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_FIN: begin
            if (out_free) begin
               ov_in       = 1'b1;
               o_status_in = status_ff;
               o_data_in   = '0;
               o_last_in   = 1'b1;
               o_fill_in   = fill_ff;
               o_free_in   = free_ff;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         rdv_ff   <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         rdv_ff   <= rdv_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      rp_ff       <= rp_in;
      cnt_ff      <= cnt_in;
      outcnt_ff   <= outcnt_in;
      len_ff      <= len_in;
      wb_ff       <= wb_in;
      status_ff   <= status_in;
      fill_ff     <= fill_in;
      free_ff     <= free_in;
      o_status_ff <= o_status_in;
      o_data_ff   <= o_data_in;
      o_last_ff   <= o_last_in;
      o_fill_ff   <= o_fill_in;
      o_free_ff   <= o_free_in;
   end

   assign req_tready     = (state_ff == S_IDLE);
   assign rsp_tvalid     = ov_ff;
   assign rsp_tlast      = o_last_ff;
   assign rsp_status     = o_status_ff;
   assign rsp_data_byte  = o_data_ff;
   assign rsp_fill_level = o_fill_ff;
   assign rsp_free_space = o_free_ff;

endmodule

[rtl/byte_ring_buffer.sv]
// A command gives a single status result, but a successful read or peek of n bytes
//   gives n byte results, the last marked; a write stores its bytes before its status.
// Throughput: one command at a time; a read or peek streams one byte per cycle while
//   the response side is ready, and a write stores one byte per cycle, set by the
//   single port of the store.
// Reset: synchronous; head and tail pointers clear to empty, store contents stay.
module byte_ring_buffer #(
   parameter int CAPACITY     = 255,
   parameter int MAX_TRANSFER = 64,
   parameter int WRITE_LANES  = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // command[2:0], length[9:3], write_bytes[73:10], zero fill
   input  logic [brb_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status[1:0], data_byte[9:2], fill_level[17:10], free_space[25:18], zero fill
   output logic [brb_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tlast
);
   import brb_pkg::*;

   localparam int SLOTS = CAPACITY + 1;
   localparam int AW    = $clog2(SLOTS);

   mem_ctl_type       mem_ctl;
   logic [AW-1:0]     mem_addr;
   logic [BYTE_W-1:0] mem_wr_data;
   logic [BYTE_W-1:0] mem_rd_data;
   logic [1:0]        rsp_status;
   logic [BYTE_W-1:0] rsp_data_byte;
   logic [BYTE_W-1:0] rsp_fill_level;
   logic [BYTE_W-1:0] rsp_free_space;

   brb_ctrl #(
      .CAPACITY     (CAPACITY),
      .MAX_TRANSFER (MAX_TRANSFER),
      .WRITE_LANES  (WRITE_LANES),
      .AW           (AW)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_command     (req_tdata[2:0]),
      .req_length      (req_tdata[9:3]),
      .req_write_bytes (req_tdata[73:10]),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tlast       (rsp_tlast),
      .rsp_status      (rsp_status),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_fill_level  (rsp_fill_level),
      .rsp_free_space  (rsp_free_space),
      .mem_ctl         (mem_ctl),
      .mem_addr        (mem_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_data     (mem_rd_data)
   );

   brb_store #(
      .DEPTH (SLOTS),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   assign rsp_tdata = {6'd0, rsp_free_space, rsp_fill_level, rsp_data_byte, rsp_status};

   a_port_single_op: assert property (@(posedge clock) disable iff (reset)
      !(mem_ctl.we && mem_ctl.re))
      else $error("store written and read in one cycle");

   a_idle_on_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> !mem_ctl.we && !mem_ctl.re)
      else $error("command taken while store busy");

   a_fail_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_status != ST_OK) |-> rsp_tlast && rsp_data_byte == '0)
      else $error("failed command result not single or carries data");

   a_level_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> 8'(rsp_fill_level + rsp_free_space) == 8'(CAPACITY))
      else $error("fill and free do not add up to capacity");

endmodule

[sim/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import brb_pkg::*;

   localparam int RING_CAPACITY = 255;
   localparam int RING_SLOTS    = RING_CAPACITY + 1;
   localparam int MAX_XFER      = 64;
   localparam int LANES         = 8;
   localparam int RANDOM_ITEMS  = 370;
   localparam int CYCLE_LIMIT   = 10_000_000;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] data_byte;
      logic       last;
      logic [7:0] fill_level;
      logic [7:0] free_space;
   } ring_rsp_type;

   // Mirror of the ring plus the queue of responses it implies.
   class ring_scoreboard;
      logic [7:0]   mirror [RING_SLOTS];
      bit           written [RING_SLOTS];
      int           head;
      int           tail;
      ring_rsp_type expected_q [$];
      int           errors;
      int           checked;

      function new();
         head = 0;
         tail = 0;
         errors = 0;
         checked = 0;
         foreach (written[i]) begin
            written[i] = 1'b0;
            mirror[i] = 8'h00;
         end
      endfunction

      function int fill_level();
         if (tail >= head) return tail - head;
         return RING_SLOTS - (head - tail);
      endfunction

      function int free_space();
         return RING_CAPACITY - fill_level();
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // how many of the next n bytes from head hold data that was written
      function int readable(int n);
         int k;
         k = 0;
         while (k < n && written[(head + k) % RING_SLOTS]) k++;
         return k;
      endfunction

      function void post(logic [1:0] st, logic [7:0] d, logic lst);
         ring_rsp_type e;
         e.status     = st;
         e.data_byte  = d;
         e.last       = lst;
         e.fill_level = 8'(fill_level());
         e.free_space = 8'(free_space());
         expected_q.push_back(e);
      endfunction

      function void note_command(logic [2:0] cmd, logic [6:0] len, logic [63:0] wb);
         int         n;
         int         p;
         logic [7:0] got [$];
         n = len;
         got = {};
         if (cmd == CMD_WRITE) begin
            if (n > LANES) post(ST_BADLEN, 8'h00, 1'b1);
            else if (n > free_space()) post(ST_SHORT, 8'h00, 1'b1);
            else begin
               for (int i = 0; i < n; i++) begin
                  mirror[tail] = wb[8*i +: 8];
                  written[tail] = 1'b1;
                  tail = (tail + 1) % RING_SLOTS;
               end
               post(ST_OK, 8'h00, 1'b1);
            end
         end else if (cmd > CMD_UNADVANCE || n > MAX_XFER) begin
            post(ST_BADLEN, 8'h00, 1'b1);
         end else if (cmd == CMD_READ || cmd == CMD_PEEK) begin
            if (n > fill_level()) post(ST_SHORT, 8'h00, 1'b1);
            else if (n == 0) post(ST_OK, 8'h00, 1'b1);
            else begin
               p = head;
               for (int i = 0; i < n; i++) begin
                  got.push_back(mirror[p]);
                  p = (p + 1) % RING_SLOTS;
               end
               // fill and free in every byte response reflect the state after the command
               if (cmd == CMD_READ) head = p;
               for (int i = 0; i < n; i++) post(ST_OK, got[i], i == n - 1);
            end
         end else if (n == 0) begin
            post(ST_BADLEN, 8'h00, 1'b1);
         end else if (cmd == CMD_ADVANCE) begin
            if (n > fill_level()) post(ST_SHORT, 8'h00, 1'b1);
            else begin
               head = (head + n) % RING_SLOTS;
               post(ST_OK, 8'h00, 1'b1);
            end
         end else begin
            if (n > free_space()) post(ST_SHORT, 8'h00, 1'b1);
            else begin
               head = (head + RING_SLOTS - n) % RING_SLOTS;
               post(ST_OK, 8'h00, 1'b1);
            end
         end
      endfunction

      function void check_result(logic [31:0] t, logic tl);
         ring_rsp_type e;
         ring_rsp_type a;
         a.status     = t[1:0];
         a.data_byte  = t[9:2];
         a.last       = tl;
         a.fill_level = t[17:10];
         a.free_space = t[25:18];
         checked++;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected response status=%0d data=%02h last=%0d fill=%0d free=%0d",
                     $time, a.status, a.data_byte, a.last, a.fill_level, a.free_space);
            return;
         end
         e = expected_q.pop_front();
         if (a.status !== e.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
         end
         if (a.data_byte !== e.data_byte) begin
            errors++;
            $display("%0t: data_byte expected %02h actual %02h", $time, e.data_byte, a.data_byte);
         end
         if (a.last !== e.last) begin
            errors++;
            $display("%0t: last expected %0d actual %0d", $time, e.last, a.last);
         end
         if (a.fill_level !== e.fill_level) begin
            errors++;
            $display("%0t: fill_level expected %0d actual %0d", $time, e.fill_level,
                     a.fill_level);
         end
         if (a.free_space !== e.free_space) begin
            errors++;
            $display("%0t: free_space expected %0d actual %0d", $time, e.free_space,
                     a.free_space);
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_DATA_W-1:0]     req_tdata;    // command, length, write_bytes, zero fill
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_DATA_W-1:0]     rsp_tdata;    // status, data_byte, fill_level, free_space
   logic                      rsp_tlast;

   ring_scoreboard sb;
   int             cycles = 0;

   byte_ring_buffer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin : watchdog
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("byte_ring_buffer verification failed");
      $finish;
   end

   // idle-free stretch for the first 16 of every 64 commands
   function automatic int idle_gap(int idx);
      int r;
      r = $urandom_range(0, 99);
      if (idx % 64 < 16 || r < 70) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   task automatic send_command(input logic [2:0] c, input logic [6:0] l,
                               input logic [63:0] w, input int gap);
      req_tdata  <= {6'b0, w, l, c};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_command(c, l, w);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic pick_command(input bit filling, output logic [2:0] c, output logic [6:0] l);
      int r;
      int k;
      r = $urandom_range(0, 99);
      if (filling) begin
         if (r < 55) c = CMD_WRITE;
         else if (r < 67) c = CMD_READ;
         else if (r < 78) c = CMD_PEEK;
         else if (r < 88) c = CMD_ADVANCE;
         else if (r < 97) c = CMD_UNADVANCE;
         else c = 3'($urandom_range(5, 7));
      end else begin
         if (r < 20) c = CMD_WRITE;
         else if (r < 50) c = CMD_READ;
         else if (r < 66) c = CMD_PEEK;
         else if (r < 85) c = CMD_ADVANCE;
         else if (r < 97) c = CMD_UNADVANCE;
         else c = 3'($urandom_range(5, 7));
      end
      r = $urandom_range(0, 99);
      case (c)
         CMD_WRITE: begin
            l = (r < 90) ? 7'($urandom_range(0, LANES)) : 7'($urandom_range(LANES + 1, 127));
         end
         CMD_READ, CMD_PEEK: begin
            if (r < 75) l = 7'($urandom_range(1, 16));
            else if (r < 90) l = 7'($urandom_range(17, MAX_XFER));
            else if (r < 95) l = 7'd0;
            else l = 7'($urandom_range(MAX_XFER + 1, 127));
            // never touch slots that hold no written data
            if (l <= MAX_XFER && l <= sb.fill_level()) begin
               k = sb.readable(l);
               if (k < l) l = 7'(k);
            end
         end
         CMD_ADVANCE, CMD_UNADVANCE: begin
            if (r < 80) l = 7'($urandom_range(1, 12));
            else if (r < 90) l = 7'd0;
            else l = 7'($urandom_range(13, 127));
         end
         default: l = 7'($urandom_range(0, 127));
      endcase
   endtask

   initial begin : response_sink
      int stall_left;
      bit held;
      int r;
      stall_left = 0;
      held = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
         // one long hold-off so the buffer backs up and stalls the command side
         if (!held && sb.checked >= 80) begin
            held = 1'b1;
            stall_left = 400;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ((cycles / 256) % 4 != 0) begin
               r = $urandom_range(0, 99);
               if (r < 20) stall_left = $urandom_range(1, 3);
               else if (r < 22) stall_left = $urandom_range(15, 80);
            end
         end
      end
   end

   initial begin : stimulus
      logic [2:0]  c;
      logic [6:0]  l;
      logic [63:0] w;
      bit          filling;
      int          idx;
      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      filling = 1'b1;
      idx = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_command(CMD_WRITE, 7'd0, {$urandom, $urandom}, idle_gap(idx++));
      send_command(CMD_WRITE, 7'd8, 64'hFFFF_FFFF_FFFF_FFFF, idle_gap(idx++));
      send_command(CMD_WRITE, 7'd8, 64'h0, idle_gap(idx++));
      send_command(CMD_WRITE, 7'd9, {$urandom, $urandom}, idle_gap(idx++));
      send_command(CMD_WRITE, 7'd127, {$urandom, $urandom}, idle_gap(idx++));
      send_command(CMD_READ, 7'd0, 64'h0, idle_gap(idx++));
      send_command(CMD_PEEK, 7'd4, 64'h0, idle_gap(idx++));
      send_command(CMD_READ, 7'd5, 64'h0, idle_gap(idx++));
      send_command(CMD_PEEK, 7'd65, 64'h0, idle_gap(idx++));
      send_command(CMD_READ, 7'd127, 64'h0, idle_gap(idx++));
      send_command(CMD_READ, 7'd20, 64'h0, idle_gap(idx++));
      send_command(CMD_ADVANCE, 7'd0, 64'h0, idle_gap(idx++));
      send_command(CMD_ADVANCE, 7'd3, 64'h0, idle_gap(idx++));
      send_command(CMD_ADVANCE, 7'd50, 64'h0, idle_gap(idx++));
      send_command(CMD_UNADVANCE, 7'd0, 64'h0, idle_gap(idx++));
      send_command(CMD_UNADVANCE, 7'd2, 64'h0, idle_gap(idx++));
      send_command(CMD_UNADVANCE, 7'd127, 64'h0, idle_gap(idx++));
      send_command(3'd5, 7'd127, {$urandom, $urandom}, idle_gap(idx++));
      send_command(3'd6, 7'd1, 64'h0, idle_gap(idx++));
      send_command(3'd7, 7'd0, 64'hFFFF_FFFF_FFFF_FFFF, idle_gap(idx++));
      send_command(CMD_READ, 7'd10, 64'h0, idle_gap(idx++));
      send_command(CMD_ADVANCE, 7'd1, 64'h0, idle_gap(idx++));
      send_command(CMD_PEEK, 7'd1, 64'h0, idle_gap(idx++));

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (sb.fill_level() >= 235) filling = 1'b0;
         else if (sb.fill_level() <= 8) filling = 1'b1;
         pick_command(filling, c, l);
         w = {$urandom, $urandom};
         send_command(c, l, w, idle_gap(idx++));
      end
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("byte_ring_buffer verification clean");
      end else begin
         if (sb.pending() != 0) $display("%0t: %0d responses never arrived", $time, sb.pending());
         $display("byte_ring_buffer verification failed");
      end
      $finish;
   end

endmodule

[files.f]
rtl/brb_pkg.sv
rtl/brb_store.sv
rtl/brb_ctrl.sv
rtl/byte_ring_buffer.sv
sim/testbench.sv
